[sv/cwt_pkg.sv]
package cwt_pkg;

    localparam int PC_W = 5;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_ADD    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_UPDATE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_PRESENT   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [63:0] id_low;
        logic [19:0] id_high;
        logic [7:0]  level;
        logic        active;
    } t_entry;

    typedef enum logic [3:0] {
        A_NOP,
        A_READ,
        A_INC,
        A_HIT,
        A_ST_DUP,
        A_ST_NF,
        A_ST_FULL,
        A_APPEND,
        A_UPDATE,
        A_READ_NEXT,
        A_MOVE,
        A_DEC,
        A_CLEAR,
        A_DONE
    } t_action;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOSTART,
        C_OP_CLEAR,
        C_OP_BAD,
        C_END,
        C_MATCH,
        C_OP_LOOKUP,
        C_OP_UPDATE,
        C_OP_REMOVE,
        C_OP_ADD,
        C_FULL,
        C_LAST
    } t_cond;

    typedef struct packed {
        t_action          action;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] PC_CHK_CLR  = 5'd1;
    localparam logic [PC_W-1:0] PC_CHK_BAD  = 5'd2;
    localparam logic [PC_W-1:0] PC_SRD      = 5'd3;
    localparam logic [PC_W-1:0] PC_SCMP     = 5'd4;
    localparam logic [PC_W-1:0] PC_SNEXT    = 5'd5;
    localparam logic [PC_W-1:0] PC_HIT      = 5'd6;
    localparam logic [PC_W-1:0] PC_HIT_UPD  = 5'd7;
    localparam logic [PC_W-1:0] PC_HIT_REM  = 5'd8;
    localparam logic [PC_W-1:0] PC_HIT_DUP  = 5'd9;
    localparam logic [PC_W-1:0] PC_MISS     = 5'd10;
    localparam logic [PC_W-1:0] PC_MISS_NF  = 5'd11;
    localparam logic [PC_W-1:0] PC_ADD_CHK  = 5'd12;
    localparam logic [PC_W-1:0] PC_APPEND   = 5'd13;
    localparam logic [PC_W-1:0] PC_FULL     = 5'd14;
    localparam logic [PC_W-1:0] PC_UPD      = 5'd15;
    localparam logic [PC_W-1:0] PC_SH_RD    = 5'd16;
    localparam logic [PC_W-1:0] PC_SH_WR    = 5'd17;
    localparam logic [PC_W-1:0] PC_SH_END   = 5'd18;
    localparam logic [PC_W-1:0] PC_CLR      = 5'd19;
    localparam logic [PC_W-1:0] PC_DONE     = 5'd20;

    // control store: a taken condition jumps to target, else step to pc + 1
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        begin
            case (pc)
                PC_IDLE:    w = '{A_NOP,       C_NOSTART,   PC_IDLE};
                PC_CHK_CLR: w = '{A_NOP,       C_OP_CLEAR,  PC_CLR};
                PC_CHK_BAD: w = '{A_NOP,       C_OP_BAD,    PC_DONE};
                PC_SRD:     w = '{A_READ,      C_END,       PC_MISS};
                PC_SCMP:    w = '{A_NOP,       C_MATCH,     PC_HIT};
                PC_SNEXT:   w = '{A_INC,       C_ALWAYS,    PC_SRD};
                PC_HIT:     w = '{A_HIT,       C_OP_LOOKUP, PC_DONE};
                PC_HIT_UPD: w = '{A_NOP,       C_OP_UPDATE, PC_UPD};
                PC_HIT_REM: w = '{A_NOP,       C_OP_REMOVE, PC_SH_RD};
                PC_HIT_DUP: w = '{A_ST_DUP,    C_ALWAYS,    PC_DONE};
                PC_MISS:    w = '{A_NOP,       C_OP_ADD,    PC_ADD_CHK};
                PC_MISS_NF: w = '{A_ST_NF,     C_ALWAYS,    PC_DONE};
                PC_ADD_CHK: w = '{A_NOP,       C_FULL,      PC_FULL};
                PC_APPEND:  w = '{A_APPEND,    C_ALWAYS,    PC_DONE};
                PC_FULL:    w = '{A_ST_FULL,   C_ALWAYS,    PC_DONE};
                PC_UPD:     w = '{A_UPDATE,    C_ALWAYS,    PC_DONE};
                PC_SH_RD:   w = '{A_READ_NEXT, C_LAST,      PC_SH_END};
                PC_SH_WR:   w = '{A_MOVE,      C_ALWAYS,    PC_SH_RD};
                PC_SH_END:  w = '{A_DEC,       C_ALWAYS,    PC_DONE};
                PC_CLR:     w = '{A_CLEAR,     C_ALWAYS,    PC_DONE};
                PC_DONE:    w = '{A_DONE,      C_ALWAYS,    PC_IDLE};
                default:    w = '{A_NOP,       C_ALWAYS,    PC_IDLE};
            endcase
            return w;
        end
    endfunction

    // bytes past the identifier length read as zero
    function automatic logic [63:0] key_low(input logic [63:0] uid, input logic [3:0] nbytes);
        logic [63:0] k;
        begin
            for (int b = 0; b < 8; b++) begin
                k[b*8 +: 8] = (nbytes > 4'(b)) ? uid[b*8 +: 8] : 8'h00;
            end
            return k;
        end
    endfunction

    function automatic logic [19:0] key_high(input logic [15:0] uid, input logic [3:0] nbytes);
        logic [15:0] k;
        begin
            if (nbytes <= 4'd8) begin
                k = 16'h0000;
            end else if (nbytes == 4'd9) begin
                k = {8'h00, uid[7:0]};
            end else begin
                k = uid;
            end
            return {nbytes, k};
        end
    endfunction

endpackage

[sv/cwt_ram.sv]
module cwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/card_whitelist_table_core.sv]
// Card whitelist table. One command is taken when start is high and busy is low; exactly
// one result comes back later as a single-cycle o_valid pulse, which the receiver must take
// as it comes. Timing is set by the entry RAM with registered read that a small microcoded
// sequencer walks one entry at a time: a lookup, add, update or remove compares the entries
// in turn until a match or the end of the count; a remove also moves each later entry down
// one place; clear and unused opcodes skip the walk. No clearing pass after reset: entries
// past the count are never used.
module card_whitelist_table_core
    import cwt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_uid_low,
    input  logic [15:0] i_uid_high,
    input  logic [3:0]  i_uid_bytes,
    input  logic [7:0]  i_level_in,
    input  logic        i_keep_level,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic        o_authorized,
    output logic [7:0]  o_level_out,
    output logic [4:0]  o_card_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(t_entry);

    logic [PC_W-1:0] r_pc, n_pc;
    logic [CW-1:0]   r_count, r_idx;
    logic [2:0]      r_op;
    logic [63:0]     r_key_lo;
    logic [19:0]     r_key_hi;
    logic [7:0]      r_level_in;
    logic            r_keep;
    t_status         r_status;
    logic            r_found, r_auth;
    logic [7:0]      r_level;

    t_uword          uw;
    logic            take;
    logic            accept;
    logic [CW:0]     idx_inc;
    t_entry          rd_entry, wr_entry;
    logic [EW-1:0]   ram_rdata;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;

    assign uw        = ucode(r_pc);
    assign accept    = start && (r_pc == PC_IDLE);
    assign idx_inc   = {1'b0, r_idx} + 1'b1;
    assign rd_entry  = t_entry'(ram_rdata);

    // sequencer branch conditions
    always_comb begin
        case (uw.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NOSTART:   take = !start;
            C_OP_CLEAR:  take = (r_op == OP_CLEAR);
            C_OP_BAD:    take = (r_op > OP_CLEAR);
            C_END:       take = (r_idx >= r_count);
            C_MATCH:     take = (rd_entry.id_low == r_key_lo) && (rd_entry.id_high == r_key_hi);
            C_OP_LOOKUP: take = (r_op == OP_LOOKUP);
            C_OP_UPDATE: take = (r_op == OP_UPDATE);
            C_OP_REMOVE: take = (r_op == OP_REMOVE);
            C_OP_ADD:    take = (r_op == OP_ADD);
            C_FULL:      take = (r_count == CW'(TABLE_DEPTH));
            C_LAST:      take = (idx_inc >= {1'b0, r_count});
            default:     take = 1'b0;
        endcase
        n_pc = take ? uw.target : r_pc + 1'b1;
    end

    // ram port control
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_idx[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        wr_entry  = rd_entry;
        case (uw.action)
            A_READ: begin
                ram_re = 1'b1;
            end
            A_READ_NEXT: begin
                ram_re    = 1'b1;
                ram_raddr = idx_inc[AW-1:0];
            end
            A_MOVE: begin
                ram_we = 1'b1;
            end
            A_UPDATE: begin
                ram_we         = !r_keep;
                wr_entry.level = r_level_in;
            end
            A_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[AW-1:0];
                wr_entry  = '{id_low: r_key_lo, id_high: r_key_hi,
                              level: r_level_in, active: 1'b1};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    cwt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (EW'(wr_entry)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_IDLE;
            r_count <= '0;
        end else begin
            r_pc <= n_pc;
            case (uw.action)
                A_APPEND: r_count <= r_count + 1'b1;
                A_DEC:    r_count <= r_count - 1'b1;
                A_CLEAR:  r_count <= '0;
                default:  r_count <= r_count;
            endcase
        end
    end

    // command latch and result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_opcode;
            r_key_lo   <= key_low(i_uid_low, i_uid_bytes);
            r_key_hi   <= key_high(i_uid_high, i_uid_bytes);
            r_level_in <= i_level_in;
            r_keep     <= i_keep_level;
            r_idx      <= '0;
            r_status   <= ST_OK;
            r_found    <= 1'b0;
            r_auth     <= 1'b0;
            r_level    <= 8'h00;
        end else begin
            case (uw.action)
                A_INC, A_MOVE: r_idx <= idx_inc[CW-1:0];
                A_HIT: begin
                    r_found <= 1'b1;
                    r_auth  <= rd_entry.active;
                    r_level <= rd_entry.level;
                end
                A_ST_DUP:  r_status <= ST_PRESENT;
                A_ST_NF:   r_status <= ST_NOT_FOUND;
                A_ST_FULL: r_status <= ST_FULL;
                default:   r_idx <= r_idx;
            endcase
        end
    end

    assign busy         = (r_pc != PC_IDLE);
    assign o_valid      = (r_pc == PC_DONE);
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_authorized = r_auth;
    assign o_level_out  = r_level;
    assign o_card_count = 5'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("command transfer did not start the sequencer");

    a_present_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_PRESENT) |-> o_found)
        else $error("duplicate reported without a match");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (!o_authorized && o_level_out == 8'h00))
        else $error("miss carries entry data");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_IDLE && $past(r_pc) == PC_IDLE) |-> $stable(r_count))
        else $error("entry count changed while idle");

endmodule

[dv/card_whitelist_table_core_test.sv]
`timescale 1ns / 1ps

module card_whitelist_table_core_test;
    import cwt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int ROSTER_SIZE = 20;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

    typedef struct packed {
        logic [63:0] lo;
        logic [19:0] hi;
    } card_key_t;

    typedef struct packed {
        t_status     status;
        logic        found;
        logic        authorized;
        logic [7:0]  level;
        logic [4:0]  count;
    } card_result_t;

    typedef struct packed {
        logic [63:0] lo;
        logic [15:0] hi;
        logic [3:0]  nb;
    } roster_id_t;

    typedef struct packed {
        logic [2:0]   op;
        logic [63:0]  lo;
        logic [15:0]  hi;
        logic [3:0]   nb;
        logic [7:0]   lvl;
        logic         keep;
        logic [4:0]   reps;
        logic         pinned;
        card_result_t want;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 18;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_opcode;
    logic [63:0] i_uid_low;
    logic [15:0] i_uid_high;
    logic [3:0]  i_uid_bytes;
    logic [7:0]  i_level_in;
    logic        i_keep_level;
    logic        o_valid;
    logic [1:0]  o_status;
    logic        o_found;
    logic        o_authorized;
    logic [7:0]  o_level_out;
    logic [4:0]  o_card_count;

    card_whitelist_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_opcode(i_opcode),
        .i_uid_low(i_uid_low),
        .i_uid_high(i_uid_high),
        .i_uid_bytes(i_uid_bytes),
        .i_level_in(i_level_in),
        .i_keep_level(i_keep_level),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_found(o_found),
        .o_authorized(o_authorized),
        .o_level_out(o_level_out),
        .o_card_count(o_card_count)
    );

    always #2 i_clk = ~i_clk;

    // shadow copy of the whitelist
    card_key_t    held_key [TABLE_DEPTH];
    logic [7:0]   held_level [TABLE_DEPTH];
    logic         held_active [TABLE_DEPTH];
    int           held_count = 0;

    card_result_t pending_results [$];
    card_result_t pinned_results [int];
    roster_id_t   roster [$];
    int           sent_items = 0;
    int           taken_items = 0;
    int           mismatches = 0;
    int           idle_pct = 0;
    int           stall_cycles = 0;

    // directed sequence; rows with pinned set carry the result typed in
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_LOOKUP, 64'h0000_0000_dead_beef, 16'h0000, 4'd4, 8'h00, 1'b0, 5'd1, 1'b1,
          '{ST_NOT_FOUND, 1'b0, 1'b0, 8'h00, 5'd0}},
        '{OP_CLEAR, 64'h0, 16'h0000, 4'd4, 8'h00, 1'b0, 5'd1, 1'b1,
          '{ST_OK, 1'b0, 1'b0, 8'h00, 5'd0}},
        '{OP_UNUSED_LAST, '1, 16'hffff, 4'd10, 8'hff, 1'b1, 5'd1, 1'b1,
          '{ST_OK, 1'b0, 1'b0, 8'h00, 5'd0}},
        '{OP_ADD, '1, 16'hffff, 4'd4, 8'hff, 1'b0, 5'd1, 1'b1,
          '{ST_OK, 1'b0, 1'b0, 8'h00, 5'd1}},
        // same four bytes with garbage above the length
        '{OP_ADD, 64'h1234_5678_ffff_ffff, 16'h5a5a, 4'd4, 8'h00, 1'b0, 5'd1, 1'b1,
          '{ST_PRESENT, 1'b1, 1'b1, 8'hff, 5'd1}},
        '{OP_ADD, '1, 16'hffff, 4'd10, 8'h00, 1'b0, 5'd1, 1'b1,
          '{ST_OK, 1'b0, 1'b0, 8'h00, 5'd2}},
        '{OP_ADD, '1, 16'hffff, 4'd8, 8'h5a, 1'b0, 5'd1, 1'b1,
          '{ST_OK, 1'b0, 1'b0, 8'h00, 5'd3}},
        '{OP_ADD, '1, 16'hffff, 4'd9, 8'ha5, 1'b0, 5'd1, 1'b1,
          '{ST_OK, 1'b0, 1'b0, 8'h00, 5'd4}},
        // zero length keeps no identifier bits
        '{OP_ADD, 64'h5555_5555_5555_5555, 16'haaaa, 4'd0, 8'h01, 1'b0, 5'd1, 1'b1,
          '{ST_OK, 1'b0, 1'b0, 8'h00, 5'd5}},
        '{OP_ADD, '1, 16'hffff, 4'd15, 8'h02, 1'b0, 5'd1, 1'b1,
          '{ST_OK, 1'b0, 1'b0, 8'h00, 5'd6}},
        '{OP_UPDATE, '1, 16'hffff, 4'd10, 8'h33, 1'b1, 5'd1, 1'b1,
          '{ST_OK, 1'b1, 1'b1, 8'h00, 5'd6}},
        '{OP_UPDATE, '1, 16'hffff, 4'd9, 8'h80, 1'b0, 5'd1, 1'b1,
          '{ST_OK, 1'b1, 1'b1, 8'ha5, 5'd6}},
        '{OP_REMOVE, '1, 16'h0000, 4'd4, 8'h00, 1'b0, 5'd1, 1'b1,
          '{ST_OK, 1'b1, 1'b1, 8'hff, 5'd5}},
        '{OP_UPDATE, 64'h0000_0000_0000_0bad, 16'h0000, 4'd6, 8'h07, 1'b0, 5'd1, 1'b1,
          '{ST_NOT_FOUND, 1'b0, 1'b0, 8'h00, 5'd5}},
        // fill the table to the top
        '{OP_ADD, 64'h0123_4567_89ab_cdef, 16'h0000, 4'd8, 8'h10, 1'b0, 5'd11, 1'b0, '0},
        '{OP_ADD, 64'h0000_0000_0000_0077, 16'h0000, 4'd6, 8'h11, 1'b0, 5'd1, 1'b1,
          '{ST_FULL, 1'b0, 1'b0, 8'h00, 5'd16}},
        // duplicate wins over full
        '{OP_ADD, '1, 16'hffff, 4'd10, 8'h44, 1'b0, 5'd1, 1'b1,
          '{ST_PRESENT, 1'b1, 1'b1, 8'h00, 5'd16}},
        '{OP_REMOVE, 64'h0, 16'h0000, 4'd0, 8'h00, 1'b0, 5'd1, 1'b0, '0}
    };

    // identifier bits past the length are dropped, the raw length stays in the key
    function automatic card_key_t card_key(input logic [63:0] lo, input logic [15:0] hi,
                                           input logic [3:0] nb);
        card_key_t k;
        k.lo = lo;
        k.hi = {nb, hi};
        if (nb < 8) begin
            k.lo = (nb == 0) ? 64'h0 : (lo & ((64'd1 << (8 * nb)) - 64'd1));
            k.hi[15:0] = 16'h0000;
        end else if (nb == 8) begin
            k.hi[15:0] = 16'h0000;
        end else if (nb == 9) begin
            k.hi[15:8] = 8'h00;
        end
        return k;
    endfunction

    function automatic card_result_t apply_card_command(input logic [2:0] op,
                                                        input card_key_t key,
                                                        input logic [7:0] lvl,
                                                        input logic keep);
        card_result_t r;
        int hit;
        r = '{ST_OK, 1'b0, 1'b0, 8'h00, 5'd0};
        hit = -1;
        if (op <= OP_UPDATE) begin
            for (int i = 0; i < held_count; i++) begin
                if (hit < 0 && held_key[i] == key) hit = i;
            end
        end
        if (hit >= 0) begin
            r.found = 1'b1;
            r.authorized = held_active[hit];
            r.level = held_level[hit];
        end
        case (op)
            OP_LOOKUP: begin
                if (hit < 0) r.status = ST_NOT_FOUND;
            end
            OP_ADD: begin
                if (hit >= 0) begin
                    r.status = ST_PRESENT;
                end else if (held_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held_key[held_count] = key;
                    held_level[held_count] = lvl;
                    held_active[held_count] = 1'b1;
                    held_count++;
                end
            end
            OP_REMOVE: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int i = hit; i < held_count - 1; i++) begin
                        held_key[i] = held_key[i + 1];
                        held_level[i] = held_level[i + 1];
                        held_active[i] = held_active[i + 1];
                    end
                    held_count--;
                end
            end
            OP_UPDATE: begin
                if (hit < 0) r.status = ST_NOT_FOUND;
                else if (!keep) held_level[hit] = lvl;
            end
            OP_CLEAR: begin
                held_count = 0;
            end
            default: begin
            end
        endcase
        r.count = 5'(held_count);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 100) $display("%0t ERROR %s", $realtime, msg);
        mismatches++;
    endtask

    // holds the command until the transfer, then maybe idles
    task automatic issue_command(input logic [2:0] op, input logic [63:0] lo,
                                 input logic [15:0] hi, input logic [3:0] nb,
                                 input logic [7:0] lvl, input logic keep,
                                 input logic pin, input card_result_t want);
        int gap;
        if (pin) pinned_results[sent_items] = want;
        sent_items++;
        start <= 1'b1;
        i_opcode <= op;
        i_uid_low <= lo;
        i_uid_high <= hi;
        i_uid_bytes <= nb;
        i_level_in <= lvl;
        i_keep_level <= keep;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(90, 4) : $urandom_range(3, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue_random_command();
        int pick;
        int slot;
        logic [2:0] op;
        logic [63:0] lo;
        logic [15:0] hi;
        logic [3:0] nb;
        logic [7:0] lvl;
        card_key_t kept;
        pick = $urandom_range(99);
        if (pick < 34) op = OP_ADD;
        else if (pick < 54) op = OP_LOOKUP;
        else if (pick < 70) op = OP_REMOVE;
        else if (pick < 92) op = OP_UPDATE;
        else if (pick < 95) op = OP_CLEAR;
        else if (pick < 97) op = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
        else op = 3'($urandom_range(7));
        lo = {$urandom, $urandom};
        hi = 16'($urandom);
        if (roster.size() == 0 || $urandom_range(99) < 15
                || (op == OP_ADD && $urandom_range(99) < 70)) begin
            nb = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10, 4));
            if (op == OP_ADD) begin
                roster.push_back('{lo, hi, nb});
                if (roster.size() > ROSTER_SIZE) void'(roster.pop_front());
            end
        end else begin
            // known card, fresh garbage in the bits past its length
            slot = $urandom_range(roster.size() - 1);
            nb = roster[slot].nb;
            kept = card_key('1, '1, nb);
            lo = (lo & ~kept.lo) | (roster[slot].lo & kept.lo);
            hi = (hi & ~kept.hi[15:0]) | (roster[slot].hi & kept.hi[15:0]);
        end
        if ($urandom_range(7) == 0) lvl = $urandom_range(1) ? 8'hff : 8'h00;
        else lvl = 8'($urandom);
        issue_command(op, lo, hi, nb, lvl, 1'($urandom_range(1)), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin : result_check
        card_result_t want;
        card_result_t predicted;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no command pending");
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  o_status, want.status));
                    if (o_found !== want.found)
                        report_mismatch($sformatf("found got %0b want %0b",
                                                  o_found, want.found));
                    if (o_authorized !== want.authorized)
                        report_mismatch($sformatf("authorized got %0b want %0b",
                                                  o_authorized, want.authorized));
                    if (o_level_out !== want.level)
                        report_mismatch($sformatf("level got %0h want %0h",
                                                  o_level_out, want.level));
                    if (o_card_count !== want.count)
                        report_mismatch($sformatf("card count got %0d want %0d",
                                                  o_card_count, want.count));
                end
            end
            if (start && !busy) begin
                predicted = apply_card_command(i_opcode,
                                               card_key(i_uid_low, i_uid_high, i_uid_bytes),
                                               i_level_in, i_keep_level);
                if (pinned_results.exists(taken_items))
                    pending_results.push_back(pinned_results[taken_items]);
                else
                    pending_results.push_back(predicted);
                taken_items++;
            end
        end
    end

    // no transfer on either side for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_LOOKUP;
        i_uid_low = '0;
        i_uid_high = '0;
        i_uid_bytes = '0;
        i_level_in = '0;
        i_keep_level = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                issue_command(directed_rows[r].op, directed_rows[r].lo + 64'(k),
                              directed_rows[r].hi, directed_rows[r].nb, directed_rows[r].lvl,
                              directed_rows[r].keep, directed_rows[r].pinned,
                              directed_rows[r].want);
            end
        end

        idle_pct = 24;
        repeat (ITEMS_PER_PHASE) issue_random_command();
        idle_pct = 74;
        repeat (ITEMS_PER_PHASE) issue_random_command();
        idle_pct = 0;
        repeat (ITEMS_PER_PHASE) issue_random_command();

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
